/* hw/rtl/hmte_pkg.sv */
// ----------------------------------------------------------------------------
// hmte_pkg
// Shared widths, default window size and result case codes for the
// harmonic-mean throughput estimator.
// ----------------------------------------------------------------------------
package hmte_pkg;

  localparam int WINDOW_DEF = 5;

  localparam int BYTES_W  = 32;
  localparam int US_W     = 32;
  localparam int KBPS_W   = 32;
  localparam int RECIP_W  = 48;
  localparam int SCALED_W = 45;  // bytes * 8000 fits in 32 + 13 bits
  localparam int CASE_W   = 2;

  localparam logic [CASE_W-1:0] CASE_NONE = 2'd0;
  localparam logic [CASE_W-1:0] CASE_FILL = 2'd1;
  localparam logic [CASE_W-1:0] CASE_FULL = 2'd2;

endpackage

/* hw/rtl/hmte_div.sv */
// ----------------------------------------------------------------------------
// hmte_div
// Bit-serial restoring divider: one quotient bit per cycle, dividend
// shifted out at the top while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module hmte_div #(
  parameter int DVW = 51,
  parameter int DSW = 51
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic           done,
  output logic [DVW-1:0] quotient
);

  localparam int CW = $clog2(DVW + 1);

  logic [DVW-1:0] acc_r, acc_nxt;
  logic [DSW-1:0] rem_r, rem_nxt;
  logic [DSW-1:0] dsr_r, dsr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           done_r, done_nxt;

  logic [DSW:0]   rem_sh;
  logic [DSW+1:0] diff;

  always_comb begin
    rem_sh   = {rem_r, acc_r[DVW-1]};
    diff     = {1'b0, rem_sh} - {2'b00, dsr_r};
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
      cnt_nxt = CW'(DVW);
    end else if (cnt_r != '0) begin
      // keep the difference when it does not borrow
      if (diff[DSW+1]) begin
        rem_nxt = rem_sh[DSW-1:0];
        acc_nxt = {acc_r[DVW-2:0], 1'b0};
      end else begin
        rem_nxt = diff[DSW-1:0];
        acc_nxt = {acc_r[DVW-2:0], 1'b1};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = acc_r;

endmodule

/* hw/rtl/harmonic_mean_throughput_estimator.sv */
// ----------------------------------------------------------------------------
// harmonic_mean_throughput_estimator
// Sliding-window harmonic-mean bandwidth estimate over downloaded segments.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one transaction per segment:
//   has_previous, segment_bytes and download_us. Output channel
//   (out_valid / out_stall) returns one transaction per input: the estimate
//   in kbit/s and a decision case (none, filling, full).
//   A transaction without history goes from S_IDLE through S_OUT to the output
//   register. One with history runs three divisions on a single bit-serial
//   divider with a dividend of 48 + clog2(WINDOW+1) bits, stepping through the
//   states S_THR, S_RECIP, S_SUB, S_ADD, S_EST and S_OUT. That divider
//   sets the rate: one transaction at a time, in_stall is high while busy.
//   A finished result waits in the output register; the next input is taken
//   meanwhile and only its own result waits for out_stall to drop.
//   Reset (rst_n low, synchronous) empties the window and the running sum and
//   drops any pending result. Ring entries are never cleared: the fill count
//   guards them, so an entry is only read after it was written.
// ----------------------------------------------------------------------------
module harmonic_mean_throughput_estimator
  import hmte_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_has_previous,
  input  logic [BYTES_W-1:0]  in_segment_bytes,
  input  logic [US_W-1:0]     in_download_us,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [KBPS_W-1:0]   out_estimate_kbps,
  output logic [CASE_W-1:0]   out_decision_case
);

  localparam int FW  = $clog2(WINDOW + 1);             // fill count width
  localparam int SLW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SW  = RECIP_W + FW;                   // running sum width
  localparam int DVW = SW;                             // divider dividend width

  typedef enum logic [2:0] {
    S_IDLE, S_THR, S_RECIP, S_SUB, S_ADD, S_EST, S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [SW-1:0]       sum_r, sum_nxt;
  logic [FW-1:0]       fill_r, fill_nxt;
  logic [SLW-1:0]      slot_r, slot_nxt;
  logic [RECIP_W-1:0]  recip_r, recip_nxt;
  logic [KBPS_W-1:0]   est_r, est_nxt;
  logic [CASE_W-1:0]   case_r, case_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [KBPS_W-1:0]   out_est_r, out_est_nxt;
  logic [CASE_W-1:0]   out_case_r, out_case_nxt;

  // window ring and its registered read port
  logic [RECIP_W-1:0]  ring_r [WINDOW];
  logic [RECIP_W-1:0]  ring_rd_r;
  logic                ring_we;

  // shared divider
  logic                div_start;
  logic [DVW-1:0]      div_dvd;
  logic [SW-1:0]       div_dsr;
  logic                div_done;
  logic [DVW-1:0]      div_quo;

  logic [SCALED_W-1:0] scaled;
  logic [BYTES_W-1:0]  kbps;
  logic [RECIP_W-1:0]  recip_sat;
  logic [KBPS_W-1:0]   est_sat;
  logic                win_full;
  logic [SW-1:0]       sum_add;

  // bytes * 8000 as (b << 13) - (b << 7) - (b << 6)
  assign scaled = (SCALED_W'(in_segment_bytes) << 13)
                - (SCALED_W'(in_segment_bytes) << 7)
                - (SCALED_W'(in_segment_bytes) << 6);

  // clamp the segment rate to [1, 2^32-1]
  always_comb begin
    if (|div_quo[DVW-1:KBPS_W]) begin
      kbps = '1;
    end else if (div_quo[KBPS_W-1:0] == '0) begin
      kbps = KBPS_W'(1);
    end else begin
      kbps = div_quo[KBPS_W-1:0];
    end
  end

  // a rate of 1 gives exactly 2^48: saturate to fit a ring entry
  assign recip_sat = (|div_quo[DVW-1:RECIP_W]) ? '1 : div_quo[RECIP_W-1:0];
  assign est_sat   = (|div_quo[DVW-1:KBPS_W]) ? '1 : div_quo[KBPS_W-1:0];
  assign win_full  = (fill_r == FW'(WINDOW));
  assign sum_add   = sum_r + SW'(recip_r);

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    fill_nxt      = fill_r;
    slot_nxt      = slot_r;
    recip_nxt     = recip_r;
    est_nxt       = est_r;
    case_nxt      = case_r;
    out_valid_nxt = out_valid_r;
    out_est_nxt   = out_est_r;
    out_case_nxt  = out_case_r;
    ring_we       = 1'b0;
    div_start     = 1'b0;
    div_dvd       = DVW'(scaled);
    div_dsr       = (in_download_us == '0) ? SW'(1) : SW'(in_download_us);

    // drop a delivered result
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_has_previous) begin
            // first division: segment rate in kbit/s
            div_start = 1'b1;
            state_nxt = S_THR;
          end else begin
            est_nxt   = '0;
            case_nxt  = CASE_NONE;
            state_nxt = S_OUT;
          end
        end
      end
      S_THR: begin
        if (div_done) begin
          // second division: Q48 reciprocal of the rate
          div_start = 1'b1;
          div_dvd   = DVW'(1) << RECIP_W;
          div_dsr   = SW'(kbps);
          state_nxt = S_RECIP;
        end
      end
      S_RECIP: begin
        if (div_done) begin
          recip_nxt = recip_sat;
          state_nxt = S_SUB;
        end
      end
      S_SUB: begin
        // retire the oldest entry once the window is full, then overwrite it
        if (win_full) begin
          sum_nxt = sum_r - SW'(ring_rd_r);
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
        ring_we   = 1'b1;
        slot_nxt  = (slot_r == SLW'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        // third division: count * 2^48 / sum
        sum_nxt   = sum_add;
        div_start = 1'b1;
        div_dvd   = DVW'(fill_r) << RECIP_W;
        div_dsr   = sum_add;
        state_nxt = S_EST;
      end
      S_EST: begin
        if (div_done) begin
          est_nxt   = est_sat;
          case_nxt  = win_full ? CASE_FULL : CASE_FILL;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_est_nxt   = est_r;
          out_case_nxt  = case_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    recip_r    <= recip_nxt;
    est_r      <= est_nxt;
    case_r     <= case_nxt;
    out_est_r  <= out_est_nxt;
    out_case_r <= out_case_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      fill_r      <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      fill_r      <= fill_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_r[slot_r] <= recip_r;
    end
    ring_rd_r <= ring_r[slot_r];
  end

  hmte_div #(
    .DVW (DVW),
    .DSW (SW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_estimate_kbps = out_est_r;
  assign out_decision_case = out_case_r;

endmodule

/* hw/rtl/hmte_chk.sv */
// ----------------------------------------------------------------------------
// hmte_chk
// Port-level checks for the harmonic-mean throughput estimator.
// ----------------------------------------------------------------------------
module hmte_chk
  import hmte_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [KBPS_W-1:0] out_estimate_kbps,
  input logic [CASE_W-1:0] out_decision_case
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_estimate_kbps) && $stable(out_decision_case))
    else $error("result payload changed while stalled");

  // no history always answers with a zero estimate
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_decision_case == CASE_NONE |-> out_estimate_kbps == '0)
    else $error("nonzero estimate without history");

  // decision case stays within its three codes
  a_case_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_decision_case == CASE_NONE || out_decision_case == CASE_FILL
                  || out_decision_case == CASE_FULL)
    else $error("bad decision case");

  // one transaction at a time: an accepted input closes the input side
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

endmodule

bind harmonic_mean_throughput_estimator hmte_chk u_hmte_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_estimate_kbps (out_estimate_kbps),
  .out_decision_case (out_decision_case)
);
